// ===== hw/rtl/lbfc_pkg.sv =====
// shared constants for the landmark box fit check
package lbfc_pkg;

  localparam int MAX_POINTS_DEF = 128;
  localparam int COORD_W        = 16;

  // extent test: EXT_NUM * extent > SIZE_NUM * size (ratio 1.15)
  localparam int EXT_NUM  = 20;
  localparam int SIZE_NUM = 23;
  localparam int EXT_W    = 22;

endpackage

// ===== hw/rtl/lbfc_accum.sv =====
// input register and per-shape running min, max, sum and count
module lbfc_accum
  import lbfc_pkg::*;
#(
  parameter int MAX_POINTS = MAX_POINTS_DEF
) (
  input  logic                                          clk,
  input  logic                                          rst,
  input  logic                                          in_valid,
  output logic                                          in_stall,
  input  logic signed [COORD_W-1:0]                     point_x,
  input  logic signed [COORD_W-1:0]                     point_y,
  input  logic signed [COORD_W-1:0]                     box_center_x,
  input  logic signed [COORD_W-1:0]                     box_center_y,
  input  logic        [COORD_W-1:0]                     box_width,
  input  logic        [COORD_W-1:0]                     box_height,
  input  logic                                          last_point,
  input  logic                                          check_advance,
  output logic                                          snap_valid,
  output logic signed [COORD_W-1:0]                     snap_min_x,
  output logic signed [COORD_W-1:0]                     snap_max_x,
  output logic signed [COORD_W-1:0]                     snap_min_y,
  output logic signed [COORD_W-1:0]                     snap_max_y,
  output logic signed [COORD_W+$clog2(MAX_POINTS):0]    snap_sum_x,
  output logic signed [COORD_W+$clog2(MAX_POINTS):0]    snap_sum_y,
  output logic        [$clog2(MAX_POINTS+1)-1:0]        snap_count,
  output logic signed [COORD_W-1:0]                     snap_center_x,
  output logic signed [COORD_W-1:0]                     snap_center_y,
  output logic        [COORD_W-1:0]                     snap_width,
  output logic        [COORD_W-1:0]                     snap_height
);

  localparam int CNT_W = $clog2(MAX_POINTS + 1);
  localparam int SUM_W = COORD_W + 1 + $clog2(MAX_POINTS);
  localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_POINTS);

  // input register
  logic                      v1;
  logic signed [COORD_W-1:0] px, py, cx, cy;
  logic        [COORD_W-1:0] bw, bh;
  logic                      last1;

  // running state
  logic signed [COORD_W-1:0] min_x, max_x, min_y, max_y;
  logic signed [SUM_W-1:0]   sum_x, sum_y;
  logic        [CNT_W-1:0]   point_count;
  logic                      first_of_shape;

  logic signed [COORD_W-1:0] min_x_next, max_x_next, min_y_next, max_y_next;
  logic signed [SUM_W-1:0]   sum_x_next, sum_y_next;
  logic        [CNT_W-1:0]   point_count_next;

  logic snap_free;
  logic s1_move;

  assign snap_free = !snap_valid || check_advance;
  assign s1_move   = v1 && (!last1 || snap_free);
  assign in_stall  = v1 && !s1_move;

  always_comb begin
    min_x_next       = min_x;
    max_x_next       = max_x;
    min_y_next       = min_y;
    max_y_next       = max_y;
    sum_x_next       = sum_x;
    sum_y_next       = sum_y;
    point_count_next = point_count;
    if (first_of_shape) begin
      min_x_next       = px;
      max_x_next       = px;
      min_y_next       = py;
      max_y_next       = py;
      sum_x_next       = SUM_W'(px);
      sum_y_next       = SUM_W'(py);
      point_count_next = CNT_W'(1);
    end else if (point_count < CNT_MAX) begin
      if (px < min_x) min_x_next = px;
      if (px > max_x) max_x_next = px;
      if (py < min_y) min_y_next = py;
      if (py > max_y) max_y_next = py;
      sum_x_next       = sum_x + SUM_W'(px);
      sum_y_next       = sum_y + SUM_W'(py);
      point_count_next = point_count + CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (!v1 || s1_move) begin
      v1 <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      px    <= point_x;
      py    <= point_y;
      cx    <= box_center_x;
      cy    <= box_center_y;
      bw    <= box_width;
      bh    <= box_height;
      last1 <= last_point;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      min_x          <= '0;
      max_x          <= '0;
      min_y          <= '0;
      max_y          <= '0;
      sum_x          <= '0;
      sum_y          <= '0;
      point_count    <= '0;
      first_of_shape <= 1'b1;
    end else if (s1_move) begin
      if (last1) begin
        min_x          <= '0;
        max_x          <= '0;
        min_y          <= '0;
        max_y          <= '0;
        sum_x          <= '0;
        sum_y          <= '0;
        point_count    <= '0;
        first_of_shape <= 1'b1;
      end else begin
        min_x          <= min_x_next;
        max_x          <= max_x_next;
        min_y          <= min_y_next;
        max_y          <= max_y_next;
        sum_x          <= sum_x_next;
        sum_y          <= sum_y_next;
        point_count    <= point_count_next;
        first_of_shape <= 1'b0;
      end
    end
  end

  // shape totals, taken on the last point
  always_ff @(posedge clk) begin
    if (rst) begin
      snap_valid <= 1'b0;
    end else if (snap_free) begin
      snap_valid <= s1_move && last1;
    end
  end

  always_ff @(posedge clk) begin
    if (snap_free && s1_move && last1) begin
      snap_min_x    <= min_x_next;
      snap_max_x    <= max_x_next;
      snap_min_y    <= min_y_next;
      snap_max_y    <= max_y_next;
      snap_sum_x    <= sum_x_next;
      snap_sum_y    <= sum_y_next;
      snap_count    <= point_count_next;
      snap_center_x <= cx;
      snap_center_y <= cy;
      snap_width    <= bw;
      snap_height   <= bh;
    end
  end

endmodule

// ===== hw/rtl/lbfc_axis_check.sv =====
// extent and mean tests for one axis, two register stages
module lbfc_axis_check
  import lbfc_pkg::*;
#(
  parameter int MAX_POINTS = MAX_POINTS_DEF
) (
  input  logic                                       clk,
  input  logic                                       advance,
  input  logic signed [COORD_W-1:0]                  snap_min,
  input  logic signed [COORD_W-1:0]                  snap_max,
  input  logic signed [COORD_W+$clog2(MAX_POINTS):0] snap_sum,
  input  logic        [$clog2(MAX_POINTS+1)-1:0]     snap_count,
  input  logic signed [COORD_W-1:0]                  snap_center,
  input  logic        [COORD_W-1:0]                  snap_size,
  output logic                                       axis_ok
);

  localparam int CNT_W = $clog2(MAX_POINTS + 1);
  localparam int SUM_W = COORD_W + 1 + $clog2(MAX_POINTS);
  localparam int PW    = CNT_W + COORD_W + 1;
  localparam int NW    = CNT_W + COORD_W;
  localparam int DW    = PW + 1;

  logic signed [COORD_W:0] extent;
  logic        [EXT_W-1:0] ext_scaled;
  logic        [EXT_W-1:0] size_scaled;
  logic signed [PW-1:0]    ncenter;
  logic        [NW-1:0]    nsize;

  // stage 3
  logic                    ext_ok3;
  logic signed [SUM_W-1:0] sum3;
  logic signed [PW-1:0]    ncenter3;
  logic        [NW-1:0]    nsize3;

  // stage 4
  logic                    ext_ok4;
  logic signed [DW-1:0]    diff4;
  logic        [NW-1:0]    nsize4;

  logic signed [DW-1:0]    diff;
  logic        [DW-1:0]    mag;

  assign extent      = (COORD_W+1)'(snap_max) - (COORD_W+1)'(snap_min);
  assign ext_scaled  = EXT_W'($unsigned(extent)) * EXT_W'(EXT_NUM);
  assign size_scaled = EXT_W'(snap_size) * EXT_W'(SIZE_NUM);
  assign ncenter     = PW'(signed'({1'b0, snap_count})) * PW'(snap_center);
  assign nsize       = NW'(snap_count) * NW'(snap_size);

  always_ff @(posedge clk) begin
    if (advance) begin
      ext_ok3  <= !(ext_scaled > size_scaled);
      sum3     <= snap_sum;
      ncenter3 <= ncenter;
      nsize3   <= nsize;
    end
  end

  assign diff = DW'(sum3) - DW'(ncenter3);

  always_ff @(posedge clk) begin
    if (advance) begin
      ext_ok4 <= ext_ok3;
      diff4   <= diff;
      nsize4  <= nsize3;
    end
  end

  assign mag     = (diff4 < 0) ? $unsigned(-diff4) : $unsigned(diff4);
  assign axis_ok = ext_ok4 && !({mag, 1'b0} > (DW+1)'(nsize4));

endmodule

// ===== hw/rtl/landmark_box_fit_check_unit.sv =====
// landmark box fit check top level
//
// input channel: one landmark point per word (coordinates, box center and
// size, last_point flag), accepted when in_valid is high and in_stall low.
// output channel: one fits_box word per shape, shown after the point
// marked last_point, accepted when out_valid is high and out_stall low.
// points of a shape arrive in order; the box fields of the last point
// are the ones checked.
// throughput: one point per cycle while in_stall is low. after the last
// point is accepted, its shape passes the input register, shape totals,
// products, difference and result register before fits_box is valid.
// the running min/max/sum update is the only loop that spans points.
// when out_stall holds a result, points that are not last keep flowing
// into the accumulators; a last point waits in the input register until
// the check pipeline can move, and in_stall is high while it waits.
// reset clears all valid flags and the running shape state; the next
// point after reset starts a new shape.
module landmark_box_fit_check_unit
  import lbfc_pkg::*;
#(
  parameter int MAX_POINTS = MAX_POINTS_DEF
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic signed [COORD_W-1:0] point_x,
  input  logic signed [COORD_W-1:0] point_y,
  input  logic signed [COORD_W-1:0] box_center_x,
  input  logic signed [COORD_W-1:0] box_center_y,
  input  logic        [COORD_W-1:0] box_width,
  input  logic        [COORD_W-1:0] box_height,
  input  logic                      last_point,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic                      fits_box
);

  localparam int CNT_W = $clog2(MAX_POINTS + 1);
  localparam int SUM_W = COORD_W + 1 + $clog2(MAX_POINTS);

  logic                      advance;
  logic                      snap_valid;
  logic                      v3, v4;
  logic signed [COORD_W-1:0] snap_min_x, snap_max_x, snap_min_y, snap_max_y;
  logic signed [SUM_W-1:0]   snap_sum_x, snap_sum_y;
  logic        [CNT_W-1:0]   snap_count;
  logic signed [COORD_W-1:0] snap_center_x, snap_center_y;
  logic        [COORD_W-1:0] snap_width, snap_height;
  logic                      ok_x, ok_y;

  assign advance = !out_valid || !out_stall;

  lbfc_accum #(
    .MAX_POINTS(MAX_POINTS)
  ) u_accum (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .point_x       (point_x),
    .point_y       (point_y),
    .box_center_x  (box_center_x),
    .box_center_y  (box_center_y),
    .box_width     (box_width),
    .box_height    (box_height),
    .last_point    (last_point),
    .check_advance (advance),
    .snap_valid    (snap_valid),
    .snap_min_x    (snap_min_x),
    .snap_max_x    (snap_max_x),
    .snap_min_y    (snap_min_y),
    .snap_max_y    (snap_max_y),
    .snap_sum_x    (snap_sum_x),
    .snap_sum_y    (snap_sum_y),
    .snap_count    (snap_count),
    .snap_center_x (snap_center_x),
    .snap_center_y (snap_center_y),
    .snap_width    (snap_width),
    .snap_height   (snap_height)
  );

  lbfc_axis_check #(
    .MAX_POINTS(MAX_POINTS)
  ) u_check_x (
    .clk         (clk),
    .advance     (advance),
    .snap_min    (snap_min_x),
    .snap_max    (snap_max_x),
    .snap_sum    (snap_sum_x),
    .snap_count  (snap_count),
    .snap_center (snap_center_x),
    .snap_size   (snap_width),
    .axis_ok     (ok_x)
  );

  lbfc_axis_check #(
    .MAX_POINTS(MAX_POINTS)
  ) u_check_y (
    .clk         (clk),
    .advance     (advance),
    .snap_min    (snap_min_y),
    .snap_max    (snap_max_y),
    .snap_sum    (snap_sum_y),
    .snap_count  (snap_count),
    .snap_center (snap_center_y),
    .snap_size   (snap_height),
    .axis_ok     (ok_y)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      v3        <= 1'b0;
      v4        <= 1'b0;
      out_valid <= 1'b0;
    end else if (advance) begin
      v3        <= snap_valid;
      v4        <= v3;
      out_valid <= v4;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      fits_box <= ok_x && ok_y;
    end
  end

endmodule
